// File: rtl/timer_queue_with_lazy_cancel_unit_assert.svh
// Assertion macros for the timer queue RTL.
`ifndef TIMER_QUEUE_WITH_LAZY_CANCEL_UNIT_ASSERT_SVH
`define TIMER_QUEUE_WITH_LAZY_CANCEL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define TQLC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer queue assertion failed");
// Next-cycle implication, checked out of reset.
`define TQLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer queue assertion failed");
`else
`define TQLC_ASSERT_IMPL(label, ante, cons)
`define TQLC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/tqlc_pkg.sv
// Shared constants, codes and types of the timer queue.
`default_nettype none
package tqlc_pkg;
    localparam int MAX_TIMERS_DEF   = 64;
    localparam int REQUEST_BITS_DEF = 8;

    localparam int MODE_W  = 2;
    localparam int REQ_W   = 8;
    localparam int TMO_W   = 24;
    localparam int KIND_W  = 3;
    localparam int STEP_W  = 10;
    localparam int DL_W    = 48;

    localparam logic [TMO_W-1:0] TIME_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NO_TIMER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE_EXP  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NEXT      = 3'd6;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd7;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ROT,
        CMD_DROP,
        CMD_ADD,
        CMD_CANCEL
    } t_cmd;

    // Broadcast to every cell each cycle.
    typedef struct packed {
        t_cmd            cmd;
        logic [DL_W-1:0] dl_new;
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: rtl/tqlc_if.sv
// Valid/ready channel interfaces: timer requests, results, step register writes.
`default_nettype none
interface tqlc_req_if;
    import tqlc_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  request_id;
    logic [TMO_W-1:0]  timeout_ms;
    modport source (output valid, mode, request_id, timeout_ms, input ready);
    modport sink   (input valid, mode, request_id, timeout_ms, output ready);
endinterface

interface tqlc_rsp_if;
    import tqlc_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [REQ_W-1:0]  expired_request;
    logic [TMO_W-1:0]  time_left_ms;
    logic              last;
    modport source (output valid, kind, expired_request, time_left_ms, last, input ready);
    modport sink   (input valid, kind, expired_request, time_left_ms, last, output ready);
endinterface

interface tqlc_cfg_if;
    import tqlc_pkg::*;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/tqlc_cell.sv
// One timer slot of the queue chain.
`default_nettype none
module tqlc_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int OWN_W = 8
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire tqlc_pkg::t_cell_ctl i_ctl,
    input  wire [CNT_W-1:0]          i_count,
    input  wire [OWN_W-1:0]          i_req,
    input  wire [tqlc_pkg::DL_W-1:0] i_nx_dl,
    input  wire [OWN_W-1:0]          i_nx_own,
    input  wire                      i_nx_cx,
    input  wire                      i_nx_new,
    input  wire [tqlc_pkg::DL_W-1:0] i_hd_dl,
    input  wire [OWN_W-1:0]          i_hd_own,
    input  wire                      i_hd_cx,
    input  wire                      i_hd_new,
    output logic [tqlc_pkg::DL_W-1:0] o_dl,
    output logic [OWN_W-1:0]          o_own,
    output logic                      o_cx,
    output logic                      o_new,
    output logic                      o_hit
);
    import tqlc_pkg::*;

    logic [DL_W-1:0]  r_dl, n_dl;
    logic [OWN_W-1:0] r_own, n_own;
    logic             r_cx, n_cx, r_new, n_new;
    logic             w_live, w_tail, w_mid, w_slot, w_match;

    assign w_live  = CNT_W'(IDX) < i_count;
    assign w_slot  = CNT_W'(IDX) == i_count;
    assign w_tail  = CNT_W'(IDX + 1) == i_count;
    assign w_mid   = CNT_W'(IDX + 1) < i_count;
    assign w_match = w_live && (r_own == i_req);

    // Newest live timer of the requester; independent of the command.
    assign o_hit   = w_match && r_new;

    always_comb begin
        n_dl  = r_dl;
        n_own = r_own;
        n_cx  = r_cx;
        n_new = r_new;
        case (i_ctl.cmd)
            CMD_ROT: begin
                if (w_tail) begin
                    n_dl = i_hd_dl; n_own = i_hd_own; n_cx = i_hd_cx; n_new = i_hd_new;
                end else if (w_mid) begin
                    n_dl = i_nx_dl; n_own = i_nx_own; n_cx = i_nx_cx; n_new = i_nx_new;
                end
            end
            CMD_DROP: begin
                n_dl = i_nx_dl; n_own = i_nx_own; n_cx = i_nx_cx; n_new = i_nx_new;
            end
            CMD_ADD: begin
                if (w_match) begin
                    n_new = 1'b0;
                end
                if (w_slot) begin
                    n_dl = i_ctl.dl_new; n_own = i_req; n_cx = 1'b0; n_new = 1'b1;
                end
            end
            CMD_CANCEL: begin
                if (w_match && r_new) begin
                    n_cx  = 1'b1;
                    n_new = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= 1'b0;
            r_new <= 1'b0;
        end else begin
            r_cx  <= n_cx;
            r_new <= n_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl  <= n_dl;
        r_own <= n_own;
    end

    assign o_dl  = r_dl;
    assign o_own = r_own;
    assign o_cx  = r_cx;
    assign o_new = r_new;
endmodule
`default_nettype wire

// File: rtl/timer_queue_with_lazy_cancel_unit.sv
// Top level of the deadline-ordered timer queue with lazy cancel.
//
// Channel  | Dir | Payload                                       | Request moves
// ---------+-----+-----------------------------------------------+------------------------
// i_req    | in  | mode, request_id, timeout_ms                  | one timer operation
// o_rsp    | out | kind, expired_request, time_left_ms, last     | one result
// i_cfg    | in  | data (tick_step_ms)                           | one step register write
//
// Add and cancel: accept, then update and result.
// Tick and query: accept and start, then per head examined a full rotation of
// the cell chain to find the earliest deadline plus a decision step; each head
// removed (due or cancelled) costs another full rotation; a tick, or a query
// with no live head, ends with a closing step that emits the result.
// The single head port of the chain is why each search is a full rotation.
// Reset is synchronous; it clears count, clock, marks and sets step to 1.
// A stalled result stalls only the cycle that wants to emit; new requests are
// taken in idle even while a result waits.
`default_nettype none
`include "timer_queue_with_lazy_cancel_unit_assert.svh"
module timer_queue_with_lazy_cancel_unit #(
    parameter int MAX_TIMERS   = tqlc_pkg::MAX_TIMERS_DEF,
    parameter int REQUEST_BITS = tqlc_pkg::REQUEST_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tqlc_req_if.sink    i_req,
    tqlc_rsp_if.source  o_rsp,
    tqlc_cfg_if.sink    i_cfg
);
    import tqlc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int IDX_W = $clog2(MAX_TIMERS);
    localparam int OWN_W = REQUEST_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;   // add / cancel, or start search
    localparam logic [2:0] S_SCAN = 3'd2;   // rotate chain, track minimum
    localparam logic [2:0] S_DEC  = 3'd3;   // judge the head found
    localparam logic [2:0] S_DROP = 3'd4;   // rotate chain, removing the head
    localparam logic [2:0] S_FIN  = 3'd5;   // final result: no live head, or none due

    logic [2:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    logic [OWN_W-1:0]  r_req;
    logic [TMO_W-1:0]  r_tmo;
    logic [DL_W-1:0]   r_clock;
    logic [STEP_W-1:0] r_step_ms;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [DL_W-1:0]   r_min_dl, n_min_dl;
    logic [IDX_W-1:0]  r_min_k, n_min_k;
    logic [OWN_W-1:0]  r_min_own, n_min_own;
    logic              r_min_cx, n_min_cx;
    logic              r_pend_v, n_pend_v;
    logic [OWN_W-1:0]  r_pend_own, n_pend_own;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [REQ_W-1:0]  r_oreq;
    logic [TMO_W-1:0]  r_left;
    logic              r_last;

    logic              w_emit;
    logic [KIND_W-1:0] w_kind;
    logic [REQ_W-1:0]  w_oreq;
    logic [TMO_W-1:0]  w_left;
    logic              w_last;
    logic              w_slot_free, w_accept, w_hit_any;
    logic [DL_W-1:0]   w_diff;
    logic [TMO_W-1:0]  w_time_left;
    t_cell_ctl         w_ctl;

    logic [DL_W-1:0]       w_dl  [MAX_TIMERS];
    logic [OWN_W-1:0]      w_own [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] w_cx, w_new, w_hit;

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
        localparam int NX = (g == MAX_TIMERS - 1) ? g : g + 1;
        tqlc_cell #(.IDX(g), .CNT_W(CNT_W), .OWN_W(OWN_W)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_count  (r_count),
            .i_req    (r_req),
            .i_nx_dl  (w_dl[NX]),
            .i_nx_own (w_own[NX]),
            .i_nx_cx  (w_cx[NX]),
            .i_nx_new (w_new[NX]),
            .i_hd_dl  (w_dl[0]),
            .i_hd_own (w_own[0]),
            .i_hd_cx  (w_cx[0]),
            .i_hd_new (w_new[0]),
            .o_dl     (w_dl[g]),
            .o_own    (w_own[g]),
            .o_cx     (w_cx[g]),
            .o_new    (w_new[g]),
            .o_hit    (w_hit[g])
        );
    end

    assign w_hit_any = |w_hit;

    // ---------------- handshakes ----------------
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    // Time left to the head, saturated.
    assign w_diff      = r_min_dl - r_clock;
    assign w_time_left = (r_min_dl <= r_clock) ? '0 :
                         ((w_diff[DL_W-1:TMO_W] != '0) ? TIME_MAX : w_diff[TMO_W-1:0]);

    // ---------------- control ----------------
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_step     = r_step;
        n_len      = r_len;
        n_min_dl   = r_min_dl;
        n_min_k    = r_min_k;
        n_min_own  = r_min_own;
        n_min_cx   = r_min_cx;
        n_pend_v   = r_pend_v;
        n_pend_own = r_pend_own;
        w_ctl.cmd    = CMD_HOLD;
        w_ctl.dl_new = r_clock + DL_W'(r_tmo);
        w_emit = 1'b0;
        w_kind = KIND_ADDED;
        w_oreq = REQ_W'(r_req);
        w_left = '0;
        w_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_OP;
                    n_pend_v = 1'b0;
                end
            end
            S_OP: begin
                n_step = '0;
                if (r_mode == MODE_ADD) begin
                    if (w_slot_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                        if (r_count == CNT_W'(MAX_TIMERS)) begin
                            w_kind = KIND_FULL;
                        end else begin
                            w_ctl.cmd = CMD_ADD;
                            n_count   = r_count + 1'b1;
                        end
                    end
                end else if (r_mode == MODE_CANCEL) begin
                    if (w_slot_free) begin
                        w_ctl.cmd = CMD_CANCEL;
                        w_emit    = 1'b1;
                        w_kind    = w_hit_any ? KIND_CANCELLED : KIND_NO_TIMER;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = (r_count != '0) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                // Head sees entries in insertion order; strict compare keeps ties oldest.
                w_ctl.cmd = CMD_ROT;
                if (r_step == '0 || w_dl[0] < r_min_dl) begin
                    n_min_dl  = w_dl[0];
                    n_min_k   = r_step;
                    n_min_own = w_own[0];
                    n_min_cx  = w_cx[0];
                end
                if (r_step == IDX_W'(r_count - 1'b1)) begin
                    n_state = S_DEC;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DEC: begin
                n_len = r_count;
                if (r_min_cx) begin
                    n_state = S_DROP;
                end else if (r_mode == MODE_QUERY) begin
                    if (w_slot_free) begin
                        w_emit  = 1'b1;
                        w_kind  = KIND_NEXT;
                        w_oreq  = REQ_W'(r_min_own);
                        w_left  = w_time_left;
                        n_state = S_IDLE;
                    end
                end else if (r_min_dl > r_clock) begin
                    n_state = S_FIN;
                end else if (!r_pend_v || w_slot_free) begin
                    // Previous expiry is now known not to be the last one.
                    w_emit     = r_pend_v;
                    w_kind     = KIND_EXPIRED;
                    w_oreq     = REQ_W'(r_pend_own);
                    w_last     = 1'b0;
                    n_pend_v   = 1'b1;
                    n_pend_own = r_min_own;
                    n_state    = S_DROP;
                end
            end
            S_DROP: begin
                if (r_step == r_min_k) begin
                    w_ctl.cmd = CMD_DROP;
                    n_count   = r_count - 1'b1;
                end else begin
                    w_ctl.cmd = CMD_ROT;
                end
                if (r_step == IDX_W'(r_len - 1'b1)) begin
                    n_step  = '0;
                    n_state = (r_len > CNT_W'(1)) ? S_SCAN : S_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_mode == MODE_QUERY) begin
                        w_kind = KIND_EMPTY;
                        w_oreq = '0;
                    end else if (r_pend_v) begin
                        w_kind = KIND_EXPIRED;
                        w_oreq = REQ_W'(r_pend_own);
                    end else begin
                        w_kind = KIND_NONE_EXP;
                        w_oreq = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_clock     <= '0;
            r_step_ms   <= STEP_W'(1);
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_step   <= n_step;
            r_pend_v <= n_pend_v;
            if (i_cfg.valid && i_cfg.ready) begin
                r_step_ms <= i_cfg.data;
            end
            if (w_accept && i_req.mode == MODE_TICK) begin
                r_clock <= r_clock + DL_W'(r_step_ms);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_req.mode;
            r_req  <= OWN_W'(i_req.request_id);
            r_tmo  <= i_req.timeout_ms;
        end
        r_len      <= n_len;
        r_min_dl   <= n_min_dl;
        r_min_k    <= n_min_k;
        r_min_own  <= n_min_own;
        r_min_cx   <= n_min_cx;
        r_pend_own <= n_pend_own;
        if (w_emit) begin
            r_kind <= w_kind;
            r_oreq <= w_oreq;
            r_left <= w_left;
            r_last <= w_last;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.kind            = r_kind;
    assign o_rsp.expired_request = r_oreq;
    assign o_rsp.time_left_ms    = r_left;
    assign o_rsp.last            = r_last;

    // ---------------- assertions ----------------
    `TQLC_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_TIMERS))
    `TQLC_ASSERT_IMPL(a_drop_nonempty, r_state == S_DROP, r_count != '0)
    `TQLC_ASSERT_IMPL(a_expiry_on_tick, w_emit && w_kind == KIND_EXPIRED, r_mode == MODE_TICK)
    `TQLC_ASSERT_NEXT(a_emit_shows, w_emit, r_out_valid)
endmodule
`default_nettype wire
